/* sv/limited_concurrency_job_queue_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the limited-concurrency job queue
// Both sample on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LIMITED_CONCURRENCY_JOB_QUEUE_DEFINES_SVH
`define LIMITED_CONCURRENCY_JOB_QUEUE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LCJQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define LCJQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/lcjq_pkg.sv */
// ---------------------------------------------------------------------------
// lcjq_pkg
// Shared constants, codes and types of the limited-concurrency job queue.
// ---------------------------------------------------------------------------
package lcjq_pkg;

	localparam int MAX_JOBS = 64;
	localparam int JOB_ID_W = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int FUNC_W   = 2;
	localparam int LIMIT_W  = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_DEFER  = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		JS_IDLE = 2'd0,
		JS_WAIT = 2'd1,
		JS_RUN  = 2'd2
	} job_state_t;

	// Write port of the job status store.
	typedef struct packed {
		logic                en;
		logic [JOB_ID_W-1:0] addr;
		job_state_t          data;
	} st_wr_t;

	// Write port of one link memory.
	typedef struct packed {
		logic                en;
		logic [JOB_ID_W-1:0] addr;
		logic [JOB_ID_W-1:0] data;
	} link_wr_t;

endpackage

/* sv/limited_concurrency_job_queue.sv */
// ---------------------------------------------------------------------------
// limited_concurrency_job_queue
// Counting-semaphore admission gate with a FIFO wait list of jobs.
// ---------------------------------------------------------------------------
// A request beat (func, job_id) is taken on req_valid high and req_stall low.
// Each request yields exactly one response beat (status, job_state, started,
// started_job, running_count, waiting_count, defer_pending), taken on
// rsp_valid high and rsp_stall low.
// The limit register is written with cfg_we / cfg_wdata; the user must do so
// only with the queue idle, unenforced; it takes effect for the next request.
// Flow: the accept edge issues one read of the status memory and of both
// link memories; the edge on which the request retires writes back and
// loads the response register. A new request is taken only once the one
// before has retired, due to the single read-modify-write pass through
// the memories per request.
// A response that the receiver stalls holds; the queue still takes one more
// request, which then waits in its second stage until the response is gone.
// Reset clears the job valid bits (all jobs idle), the list pointers, the
// counters and the deferred-start request, and sets the limit to one.
// ---------------------------------------------------------------------------
module limited_concurrency_job_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          cfg_we,
	input  logic [lcjq_pkg::LIMIT_W-1:0]  cfg_wdata,
	// Request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [lcjq_pkg::FUNC_W-1:0]   func,
	input  logic [lcjq_pkg::JOB_ID_W-1:0] job_id,
	// Response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          status,
	output logic [1:0]                    job_state,
	output logic                          started,
	output logic [lcjq_pkg::JOB_ID_W-1:0] started_job,
	output logic [lcjq_pkg::CNT_W-1:0]    running_count,
	output logic [lcjq_pkg::CNT_W-1:0]    waiting_count,
	output logic                          defer_pending
);
	import lcjq_pkg::*;

	`include "limited_concurrency_job_queue_defines.svh"

	// Architectural state held in flip-flops.
	logic [LIMIT_W-1:0]  limit_q;
	logic [JOB_ID_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0]    wait_q, run_q;
	logic                defer_q;

	// Second stage: the request whose memory reads are in flight.
	logic                valid_s1;
	func_t               func_s1;
	logic [JOB_ID_W-1:0] addr_s1;

	// Response register.
	logic                rsp_valid_q;
	logic                status_q;
	job_state_t          jstate_q;
	logic                started_q;
	logic [JOB_ID_W-1:0] sjob_q;

	logic                req_accept;
	logic                done_s1;
	logic [JOB_ID_W-1:0] rd_addr;

	job_state_t          st_cur;
	logic [JOB_ID_W-1:0] next_rd, prev_rd;

	st_wr_t              st_wr;
	link_wr_t            next_wr, prev_wr;

	logic [JOB_ID_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0]    wait_d, run_d;
	logic                defer_d;
	logic                status_d, started_d;
	job_state_t          jstate_d;
	logic [JOB_ID_W-1:0] sjob_d;

	logic                room;
	logic                do_unlink, do_push;
	logic [CNT_W:0]      live_jobs;

	// Only one request is inside at a time, so a read never meets a write
	// to the same entry: the write back lands before the next read is issued.
	assign req_stall  = valid_s1;
	assign req_accept = req_valid & ~req_stall;
	// The second stage retires once the response register is free.
	assign done_s1    = valid_s1 & (~rsp_valid_q | ~rsp_stall);

	// A deferred start works on the list head; every other request on job_id.
	assign rd_addr = (func_t'(func) == FN_DEFER) ? head_q : job_id;

	lcjq_status_store u_status (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (st_wr),
		.re     (req_accept),
		.raddr  (rd_addr),
		.rdata  (st_cur)
	);

	lcjq_ram #(.DEPTH(MAX_JOBS), .WIDTH(JOB_ID_W)) u_next_link (
		.clk   (clk),
		.we    (next_wr.en),
		.waddr (next_wr.addr),
		.wdata (next_wr.data),
		.re    (req_accept),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	lcjq_ram #(.DEPTH(MAX_JOBS), .WIDTH(JOB_ID_W)) u_prev_link (
		.clk   (clk),
		.we    (prev_wr.en),
		.waddr (prev_wr.addr),
		.wdata (prev_wr.data),
		.re    (req_accept),
		.raddr (rd_addr),
		.rdata (prev_rd)
	);

	assign room = run_q < CNT_W'(limit_q);

	// Read-modify-write of the second stage.
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		wait_d    = wait_q;
		run_d     = run_q;
		defer_d   = defer_q;
		status_d  = 1'b0;
		started_d = 1'b0;
		sjob_d    = '0;
		jstate_d  = JS_IDLE;
		do_unlink = 1'b0;
		do_push   = 1'b0;
		st_wr     = '{en: 1'b0, addr: addr_s1, data: JS_IDLE};
		next_wr   = '{en: 1'b0, addr: '0, data: '0};
		prev_wr   = '{en: 1'b0, addr: '0, data: '0};

		case (func_s1)
			FN_ADD: begin
				if (st_cur != JS_IDLE) begin
					// Job already queued or running: refused, nothing changes.
					status_d = 1'b1;
					jstate_d = st_cur;
				end else if (wait_q == '0 && room) begin
					st_wr.en   = 1'b1;
					st_wr.data = JS_RUN;
					run_d      = run_q + CNT_W'(1);
					started_d  = 1'b1;
					sjob_d     = addr_s1;
					jstate_d   = JS_RUN;
				end else begin
					st_wr.en   = 1'b1;
					st_wr.data = JS_WAIT;
					do_push    = 1'b1;
					jstate_d   = JS_WAIT;
				end
			end
			FN_REMOVE: begin
				if (st_cur == JS_WAIT) begin
					do_unlink = 1'b1;
					st_wr.en  = 1'b1;
				end else if (st_cur == JS_RUN) begin
					// Freeing a slot exactly at the limit asks for a deferred start.
					if (run_q == CNT_W'(limit_q)) begin
						defer_d = 1'b1;
					end
					if (run_q != '0) begin
						run_d = run_q - CNT_W'(1);
					end
					st_wr.en = 1'b1;
				end
			end
			FN_DEFER: begin
				defer_d = 1'b0;
				if (wait_q != '0 && room) begin
					do_unlink  = 1'b1;
					st_wr.en   = 1'b1;
					st_wr.data = JS_RUN;
					run_d      = run_q + CNT_W'(1);
					// Keep the request up while room and waiters remain.
					if ((wait_q - CNT_W'(1)) != '0 &&
					    (run_q + CNT_W'(1)) < CNT_W'(limit_q)) begin
						defer_d = 1'b1;
					end
					started_d  = 1'b1;
					sjob_d     = addr_s1;
					jstate_d   = JS_RUN;
				end
			end
			default: begin
				jstate_d = st_cur;
			end
		endcase

		if (do_push) begin
			if (wait_q == '0) begin
				head_d = addr_s1;
			end else begin
				next_wr = '{en: 1'b1, addr: tail_q, data: addr_s1};
				prev_wr = '{en: 1'b1, addr: addr_s1, data: tail_q};
			end
			tail_d = addr_s1;
			wait_d = wait_q + CNT_W'(1);
		end

		if (do_unlink) begin
			if (addr_s1 == head_q && addr_s1 == tail_q) begin
				head_d = '0;
				tail_d = '0;
			end else if (addr_s1 == head_q) begin
				head_d = next_rd;
			end else if (addr_s1 == tail_q) begin
				tail_d = prev_rd;
			end else begin
				// Middle of the list: bridge the neighbors.
				next_wr = '{en: 1'b1, addr: prev_rd, data: next_rd};
				prev_wr = '{en: 1'b1, addr: next_rd, data: prev_rd};
			end
			if (wait_q != '0) begin
				wait_d = wait_q - CNT_W'(1);
			end
		end

		// Nothing is written unless the stage actually retires.
		st_wr.en   = st_wr.en & done_s1;
		next_wr.en = next_wr.en & done_s1;
		prev_wr.en = prev_wr.en & done_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			wait_q      <= '0;
			run_q       <= '0;
			defer_q     <= 1'b0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (req_accept) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				wait_q      <= wait_d;
				run_q       <= run_d;
				defer_q     <= defer_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			func_s1 <= func_t'(func);
			addr_s1 <= rd_addr;
		end
		if (done_s1) begin
			status_q  <= status_d;
			jstate_q  <= jstate_d;
			started_q <= started_d;
			sjob_q    <= sjob_d;
		end
	end

	// The counters and the deferred request only change when a new response
	// is loaded, so they are the response's totals as long as it is shown.
	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign job_state     = jstate_q;
	assign started       = started_q;
	assign started_job   = sjob_q;
	assign running_count = run_q;
	assign waiting_count = wait_q;
	assign defer_pending = defer_q;

	assign live_jobs = {1'b0, run_q} + {1'b0, wait_q};

	`LCJQ_ASSERT_ALWAYS(a_jobs_bounded, live_jobs <= (CNT_W + 1)'(MAX_JOBS), "too many live jobs")
	`LCJQ_ASSERT_IMPL(a_empty_list_ptrs, wait_q == '0, (head_q | tail_q) == '0, "stale list ends")
	`LCJQ_ASSERT_IMPL(a_single_waiter, wait_q == CNT_W'(1), head_q == tail_q, "one waiter, two ends")
	`LCJQ_ASSERT_IMPL(a_started_runs, rsp_valid_q && started_q, jstate_q == JS_RUN, "start not running")

endmodule

/* sv/lcjq_ram.sv */
// ---------------------------------------------------------------------------
// lcjq_ram
// Generic single-write, single-read synchronous RAM, read data registered.
// ---------------------------------------------------------------------------
module lcjq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/lcjq_status_store.sv */
// ---------------------------------------------------------------------------
// lcjq_status_store
// Job status memory with one valid bit per job; an unwritten job reads idle.
// ---------------------------------------------------------------------------
module lcjq_status_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcjq_pkg::st_wr_t              wr,
	input  logic                          re,
	input  logic [lcjq_pkg::JOB_ID_W-1:0] raddr,
	output lcjq_pkg::job_state_t          rdata
);
	import lcjq_pkg::*;

	job_state_t            mem [MAX_JOBS];
	logic [MAX_JOBS-1:0]   vld_q;
	job_state_t            raw_q;
	logic                  rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (re) begin
			raw_q <= mem[raddr];
		end
	end

	assign rdata = rvld_q ? raw_q : JS_IDLE;

endmodule
